// ===== hdl/dltq_pkg.sv =====
// Shared types and constants for the delta list timer queue.
// No dependencies; every other file imports this package.
package dltq_pkg;

   localparam int DELTA_W = 16;
   localparam int PORT_W  = 16;
   localparam int SEQ_W   = 32;
   localparam int OP_W    = 2;
   localparam int KIND_W  = 3;

   // Expiries reported by one tick at most.
   localparam int MAX_EXPIRE = 16;
   localparam int NPOP_W     = $clog2(MAX_EXPIRE + 1);

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;

   typedef struct packed {
      logic [DELTA_W-1:0] delta;
      logic [PORT_W-1:0]  port;
      logic [SEQ_W-1:0]   seq;
   } entry_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PORT_W-1:0] out_port;
      logic [SEQ_W-1:0]  out_seq;
      logic              last;
   } result_type;

endpackage

// ===== hdl/dltq_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on dltq_pkg for field widths.
interface dltq_req_if import dltq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    opcode;
   logic [DELTA_W-1:0] delay;
   logic [PORT_W-1:0]  port;
   logic [SEQ_W-1:0]   seq;

   modport source (output valid, output opcode, output delay, output port, output seq,
                   input ready);
   modport sink   (input valid, input opcode, input delay, input port, input seq,
                   output ready);
endinterface

interface dltq_rsp_if import dltq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [PORT_W-1:0] out_port;
   logic [SEQ_W-1:0]  out_seq;
   logic              last;

   modport source (output valid, output kind, output out_port, output out_seq, output last,
                   input ready);
   modport sink   (input valid, input kind, input out_port, input out_seq, input last,
                   output ready);
endinterface

// ===== hdl/delta_list_timer_queue_core.sv =====
// Delta list timer queue: top level tying sequencer, entry RAM and output register.
// Depends on dltq_pkg, dltq_if, dltq_entry_ram, dltq_rsp_reg and dltq_seq.
//
// Usage:
//  req_ch takes one command word per accepted handshake: add (delay, port, seq),
//  cancel (seq) or tick. rsp_ch returns result words; last marks the final word
//  of a command. Add and cancel give exactly one word, a tick gives zero to 16
//  expiry words, unused opcodes give none.
//  The list sits in a circular buffer in a single-port-write RAM, one entry per
//  slot. Commands are handled one at a time, each in these steps:
//   add    : walk to the insertion point an entry at a time, then shift the
//            tail up an entry at a time and write the new entry; no shift
//            when the entry lands at the tail.
//   cancel : walk to the match, then shift the tail down.
//   tick   : pop expired entries, none read on an empty list; pops just
//            advance the head pointer.
//  The RAM's single write port and registered read pace these steps. The result
//  word shows on rsp_ch in the cycle req_ch turns ready again.
//  Reset empties the list at once (count and head clear, no RAM sweep).
//  A result word waits in the output register while rsp_ch stalls; a new
//  command can still be accepted, and the sequencer holds when it needs the
//  register again.
module delta_list_timer_queue_core import dltq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   dltq_req_if.sink   req_ch,
   dltq_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   entry_type     ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   entry_type     ram_rdata;

   logic          rsp_load;
   logic          rsp_free;
   result_type    rsp_data;
   logic [CW-1:0] entry_count;

   dltq_seq #(.DEPTH(DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_free  (rsp_free),
      .rsp_load  (rsp_load),
      .rsp_data  (rsp_data),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .count     (entry_count)
   );

   dltq_entry_ram #(.DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   dltq_rsp_reg u_rsp (
      .clock  (clock),
      .reset  (reset),
      .load   (rsp_load),
      .data   (rsp_data),
      .free   (rsp_free),
      .rsp_ch (rsp_ch)
   );

   // shifts and walks never read the slot being written in the same cycle
   a_ram_no_collide: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("entry RAM read and write hit the same slot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count <= CW'(DEPTH))
      else $error("entry count beyond table depth");

   // a result is never loaded over a word the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("result word overwritten while stalled");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (entry_count != $past(entry_count)) |->
         ((entry_count == $past(entry_count) + CW'(1)) ||
          (entry_count == $past(entry_count) - CW'(1)) || $past(reset)))
      else $error("entry count moved by more than one");

endmodule

// ===== hdl/dltq_entry_ram.sv =====
// Entry storage: one write port, one read port, registered read data.
// Depends on dltq_pkg (entry_type).
module dltq_entry_ram import dltq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  entry_type                wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output entry_type                rdata
);

   entry_type entry_mem [DEPTH];
   entry_type rdata_ff;

   // read data holds when no read is issued; the sequencer relies on that while stalled
   always_ff @(posedge clock) begin
      if (we) begin
         entry_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= entry_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/dltq_rsp_reg.sv =====
// Output register for response words; frees the sequencer from the receiver.
// Depends on dltq_pkg (result_type) and dltq_rsp_if.
module dltq_rsp_reg import dltq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type data,
   output logic       free,
   dltq_rsp_if.source rsp_ch
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free     = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.kind     = data_ff.kind;
   assign rsp_ch.out_port = data_ff.out_port;
   assign rsp_ch.out_seq  = data_ff.out_seq;
   assign rsp_ch.last     = data_ff.last;

endmodule

// ===== hdl/dltq_seq.sv =====
// Sequencer: walks, shifts and pops the delta list held in the entry RAM.
// Depends on dltq_pkg and dltq_req_if.
module dltq_seq import dltq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   dltq_req_if.sink                   req_ch,
   input  logic                       out_free,
   output logic                       rsp_load,
   output result_type                 rsp_data,
   output logic                       ram_we,
   output logic [$clog2(DEPTH)-1:0]   ram_waddr,
   output entry_type                  ram_wdata,
   output logic                       ram_re,
   output logic [$clog2(DEPTH)-1:0]   ram_raddr,
   input  entry_type                  ram_rdata,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int PW    = AW + 1;
   localparam int SUM_W = DELTA_W + AW + 1;
   localparam logic [PW-1:0] PHYS_LIM = PW'(DEPTH);

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b00_0000_0001,
      ST_ADD_WALK   = 10'b00_0000_0010,
      ST_ADD_PREP   = 10'b00_0000_0100,
      ST_ADD_SHIFT  = 10'b00_0000_1000,
      ST_ADD_INS    = 10'b00_0001_0000,
      ST_CAN_WALK   = 10'b00_0010_0000,
      ST_CAN_SHIFT  = 10'b00_0100_0000,
      ST_TICK_CHK   = 10'b00_1000_0000,
      ST_TICK_FLUSH = 10'b01_0000_0000,
      ST_RESP       = 10'b10_0000_0000
   } state_type;

   // circular buffer: logical entry ofs lives at head + ofs, wrapped
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [CW-1:0] ofs);
      logic [PW-1:0] s;
      s = {1'b0, base} + PW'(ofs);
      if (s >= PHYS_LIM) begin
         s = s - PHYS_LIM;
      end
      return s[AW-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [DELTA_W-1:0] nd_ff, nd_in;
   logic [DELTA_W-1:0] carry_ff, carry_in;
   logic [DELTA_W-1:0] delay_ff, delay_in;
   logic [PORT_W-1:0]  port_ff, port_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [NPOP_W-1:0]  npop_ff, npop_in;
   logic               pend_ff, pend_in;
   logic [KIND_W-1:0]  res_kind_ff, res_kind_in;
   logic [PORT_W-1:0]  res_port_ff, res_port_in;
   logic [SEQ_W-1:0]   res_seq_ff, res_seq_in;

   logic               accept;
   logic [SUM_W-1:0]   sum_next;
   logic               hit;
   logic [DELTA_W-1:0] nd_hit;
   logic [DELTA_W-1:0] d_tick;
   logic               pop;
   logic               more_next;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign count        = count_ff;

   assign sum_next  = sum_ff + SUM_W'(ram_rdata.delta);
   // the head takes equal delays in front of it; later entries let ties pass
   assign hit       = (idx_ff == '0) ? (ram_rdata.delta >= delay_ff)
                                     : (sum_next > SUM_W'(delay_ff));
   assign nd_hit    = delay_ff - sum_ff[DELTA_W-1:0];
   assign more_next = (idx_ff + CW'(1)) < count_ff;
   assign d_tick    = (npop_ff != '0) ? ram_rdata.delta :
                      (ram_rdata.delta == '0) ? '0 : ram_rdata.delta - DELTA_W'(1);
   assign pop       = (d_tick == '0);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      nd_in       = nd_ff;
      carry_in    = carry_ff;
      delay_in    = delay_ff;
      port_in     = port_ff;
      seq_in      = seq_ff;
      npop_in     = npop_ff;
      pend_in     = pend_ff;
      res_kind_in = res_kind_ff;
      res_port_in = res_port_ff;
      res_seq_in  = res_seq_ff;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = ram_rdata;
      ram_re      = 1'b0;
      ram_raddr   = '0;
      rsp_load    = 1'b0;
      rsp_data    = '{kind: res_kind_ff, out_port: res_port_ff, out_seq: res_seq_ff,
                      last: 1'b1};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               delay_in = req_ch.delay;
               port_in  = req_ch.port;
               seq_in   = req_ch.seq;
               idx_in   = '0;
               sum_in   = '0;
               npop_in  = '0;
               pend_in  = 1'b0;
               unique case (req_ch.opcode)
                  OP_ADD: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_kind_in = KIND_REJECTED;
                        res_port_in = req_ch.port;
                        res_seq_in  = req_ch.seq;
                        state_in    = ST_RESP;
                     end else if (count_ff == '0) begin
                        pos_in   = '0;
                        nd_in    = req_ch.delay;
                        state_in = ST_ADD_INS;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = head_ff;
                        state_in  = ST_ADD_WALK;
                     end
                  end
                  OP_CANCEL: begin
                     if (count_ff == '0) begin
                        res_kind_in = KIND_NOT_FOUND;
                        res_port_in = '0;
                        res_seq_in  = req_ch.seq;
                        state_in    = ST_RESP;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = head_ff;
                        state_in  = ST_CAN_WALK;
                     end
                  end
                  OP_TICK: begin
                     if (count_ff != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = head_ff;
                        state_in  = ST_TICK_CHK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_ADD_WALK: begin
            if (hit) begin
               // entry idx moves behind the new one and gives up nd of its delta
               ram_we    = 1'b1;
               ram_waddr = phys(head_ff, idx_ff);
               ram_wdata = '{delta: ram_rdata.delta - nd_hit, port: ram_rdata.port,
                             seq: ram_rdata.seq};
               pos_in    = idx_ff;
               nd_in     = nd_hit;
               idx_in    = count_ff;
               state_in  = ST_ADD_PREP;
            end else if (more_next) begin
               ram_re    = 1'b1;
               ram_raddr = phys(head_ff, idx_ff + CW'(1));
               idx_in    = idx_ff + CW'(1);
               sum_in    = sum_next;
            end else begin
               nd_in    = delay_ff - sum_next[DELTA_W-1:0];
               pos_in   = count_ff;
               state_in = ST_ADD_INS;
            end
         end

         ST_ADD_PREP: begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_ff, idx_ff - CW'(1));
            state_in  = ST_ADD_SHIFT;
         end

         ST_ADD_SHIFT: begin
            // move entry idx-1 up to idx, tail first
            ram_we    = 1'b1;
            ram_waddr = phys(head_ff, idx_ff);
            ram_wdata = ram_rdata;
            if ((idx_ff - CW'(1)) == pos_ff) begin
               state_in = ST_ADD_INS;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = phys(head_ff, idx_ff - CW'(2));
               idx_in    = idx_ff - CW'(1);
            end
         end

         ST_ADD_INS: begin
            ram_we      = 1'b1;
            ram_waddr   = phys(head_ff, pos_ff);
            ram_wdata   = '{delta: nd_ff, port: port_ff, seq: seq_ff};
            count_in    = count_ff + CW'(1);
            res_kind_in = KIND_ADDED;
            res_port_in = port_ff;
            res_seq_in  = seq_ff;
            state_in    = ST_RESP;
         end

         ST_CAN_WALK: begin
            if (ram_rdata.seq == seq_ff) begin
               res_kind_in = KIND_CANCELLED;
               res_port_in = ram_rdata.port;
               res_seq_in  = ram_rdata.seq;
               carry_in    = ram_rdata.delta;
               if (more_next) begin
                  ram_re    = 1'b1;
                  ram_raddr = phys(head_ff, idx_ff + CW'(1));
                  state_in  = ST_CAN_SHIFT;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = ST_RESP;
               end
            end else if (more_next) begin
               ram_re    = 1'b1;
               ram_raddr = phys(head_ff, idx_ff + CW'(1));
               idx_in    = idx_ff + CW'(1);
            end else begin
               res_kind_in = KIND_NOT_FOUND;
               res_port_in = '0;
               res_seq_in  = seq_ff;
               state_in    = ST_RESP;
            end
         end

         ST_CAN_SHIFT: begin
            // move entry idx+1 down to idx; the first one inherits the removed delta
            ram_we    = 1'b1;
            ram_waddr = phys(head_ff, idx_ff);
            ram_wdata = '{delta: ram_rdata.delta + carry_ff, port: ram_rdata.port,
                          seq: ram_rdata.seq};
            carry_in  = '0;
            if ((idx_ff + CW'(2)) < count_ff) begin
               ram_re    = 1'b1;
               ram_raddr = phys(head_ff, idx_ff + CW'(2));
               idx_in    = idx_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_RESP;
            end
         end

         ST_TICK_CHK: begin
            // a held expiry waits here until the output register can take it
            if (!(pend_ff && !out_free)) begin
               if (npop_ff == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = head_ff;
                  ram_wdata = '{delta: d_tick, port: ram_rdata.port, seq: ram_rdata.seq};
               end
               if (pend_ff) begin
                  rsp_load = 1'b1;
                  rsp_data = '{kind: KIND_EXPIRED, out_port: res_port_ff,
                               out_seq: res_seq_ff, last: !pop};
               end
               if (pop) begin
                  pend_in     = 1'b1;
                  res_port_in = ram_rdata.port;
                  res_seq_in  = ram_rdata.seq;
                  head_in     = phys(head_ff, CW'(1));
                  count_in    = count_ff - CW'(1);
                  npop_in     = npop_ff + NPOP_W'(1);
                  if ((count_ff > CW'(1)) &&
                      ((npop_ff + NPOP_W'(1)) < NPOP_W'(MAX_EXPIRE))) begin
                     ram_re    = 1'b1;
                     ram_raddr = phys(head_ff, CW'(1));
                  end else begin
                     state_in = ST_TICK_FLUSH;
                  end
               end else begin
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_TICK_FLUSH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_data = '{kind: KIND_EXPIRED, out_port: res_port_ff, out_seq: res_seq_ff,
                            last: 1'b1};
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end

         ST_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      sum_ff      <= sum_in;
      nd_ff       <= nd_in;
      carry_ff    <= carry_in;
      delay_ff    <= delay_in;
      port_ff     <= port_in;
      seq_ff      <= seq_in;
      npop_ff     <= npop_in;
      res_kind_ff <= res_kind_in;
      res_port_ff <= res_port_in;
      res_seq_ff  <= res_seq_in;
   end

endmodule

// ===== tb/delta_list_timer_queue_core_tb.sv =====
// Self-checking testbench for delta_list_timer_queue_core: directed and random
// add, cancel and tick words checked against a delta list kept in the bench.
// Depends on dltq_pkg, dltq_if and the core itself.
module delta_list_timer_queue_core_tb;
   import dltq_pkg::*;

   localparam int QDEPTH         = 16;
   localparam int SETTLE_CYCLES  = 2 * QDEPTH + 8;  // well past one add/cancel walk
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   // The one opcode the core ignores.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;

   dltq_req_if req_ch ();
   dltq_rsp_if rsp_ch ();

   delta_list_timer_queue_core #(.DEPTH(QDEPTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow delta list: entry 0 is the head, each delta relative to the one before.
   logic [DELTA_W-1:0] shadow_delta [QDEPTH];
   logic [PORT_W-1:0]  shadow_port  [QDEPTH];
   logic [SEQ_W-1:0]   shadow_seq   [QDEPTH];
   int                 shadow_count;

   result_type expected_results [$];   // words still owed by the core, oldest first
   int         error_count;
   int         quiet_cycles;
   bit         steady_flow;             // both sides skip their random waits

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow list maintenance
   // ---------------------------------------------------------------------
   function automatic void drop_entry(input int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_delta[i] = shadow_delta[i + 1];
         shadow_port[i]  = shadow_port[i + 1];
         shadow_seq[i]   = shadow_seq[i + 1];
      end
      shadow_count--;
   endfunction

   // Applies one accepted command word to the shadow list and queues the
   // result words it should produce.
   function automatic void predict_timer_results(input logic [OP_W-1:0]    op,
                                                 input logic [DELTA_W-1:0] delay,
                                                 input logic [PORT_W-1:0]  port,
                                                 input logic [SEQ_W-1:0]   seq);
      result_type         r;
      int                 pos;
      int                 hit;
      int                 n;
      int unsigned        run_sum;
      int unsigned        prev_sum;
      logic [DELTA_W-1:0] new_delta;

      n = 0;
      case (op)
         OP_ADD: begin
            r.out_port = port;
            r.out_seq  = seq;
            r.last     = 1'b1;
            if (shadow_count >= QDEPTH) begin
               r.kind = KIND_REJECTED;
            end else begin
               r.kind = KIND_ADDED;
               if (shadow_count == 0 || shadow_delta[0] >= delay) begin
                  // empty list, or not later than the head: new head
                  pos       = 0;
                  new_delta = delay;
                  if (shadow_count != 0)
                     shadow_delta[0] = shadow_delta[0] - delay;
               end else begin
                  // first entry whose running sum is strictly later; ties go after
                  pos      = shadow_count;
                  run_sum  = 0;
                  prev_sum = 0;
                  for (int i = 0; i < shadow_count; i++) begin
                     prev_sum = run_sum;
                     run_sum += shadow_delta[i];
                     if (run_sum > delay) begin
                        pos = i;
                        break;
                     end
                  end
                  if (pos < shadow_count) begin
                     new_delta         = delay - prev_sum;
                     shadow_delta[pos] = shadow_delta[pos] - new_delta;
                  end else begin
                     new_delta = delay - run_sum;
                  end
               end
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_delta[i] = shadow_delta[i - 1];
                  shadow_port[i]  = shadow_port[i - 1];
                  shadow_seq[i]   = shadow_seq[i - 1];
               end
               shadow_delta[pos] = new_delta;
               shadow_port[pos]  = port;
               shadow_seq[pos]   = seq;
               shadow_count++;
            end
            expected_results.push_back(r);
         end
         OP_CANCEL: begin
            hit = -1;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_seq[i] == seq) begin
                  hit = i;
                  break;
               end
            end
            r.last = 1'b1;
            if (hit < 0) begin
               r.kind     = KIND_NOT_FOUND;
               r.out_port = '0;
               r.out_seq  = seq;
            end else begin
               r.kind     = KIND_CANCELLED;
               r.out_port = shadow_port[hit];
               r.out_seq  = shadow_seq[hit];
               // the follower inherits the removed delta
               if (hit + 1 < shadow_count)
                  shadow_delta[hit + 1] = shadow_delta[hit + 1] + shadow_delta[hit];
               drop_entry(hit);
            end
            expected_results.push_back(r);
         end
         OP_TICK: begin
            if (shadow_count != 0) begin
               if (shadow_delta[0] != 0)
                  shadow_delta[0] = shadow_delta[0] - 1'b1;
               while (shadow_count > 0 && shadow_delta[0] == 0 && n < MAX_EXPIRE) begin
                  r.kind     = KIND_EXPIRED;
                  r.out_port = shadow_port[0];
                  r.out_seq  = shadow_seq[0];
                  drop_entry(0);
                  n++;
                  r.last = !(shadow_count > 0 && shadow_delta[0] == 0 && n < MAX_EXPIRE);
                  expected_results.push_back(r);
               end
            end
         end
         default: begin
            // unused opcode: no words, no state change
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side: one command word per call, random gap in front.
   // Valid stays high across back-to-back words.
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [OP_W-1:0]    op,
                            input logic [DELTA_W-1:0] delay,
                            input logic [PORT_W-1:0]  port,
                            input logic [SEQ_W-1:0]   seq);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.delay  <= delay;
      req_ch.port   <= port;
      req_ch.seq    <= seq;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_timer_results(op, delay, port, seq);
   endtask

   // Drops valid, waits for every owed word, then lets the core settle
   // (a tick with no expiry gives no word to wait for).
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR at %0t: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall before each word, ready held until taken.
   // ---------------------------------------------------------------------
   initial begin
      int stall;
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   // Checks every accepted result word against the oldest expectation.
   always @(posedge clock) begin : check_rsp
      result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            flag_error($sformatf("unexpected word kind %0d port %h seq %h last %b",
                                 rsp_ch.kind, rsp_ch.out_port, rsp_ch.out_seq, rsp_ch.last));
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.kind !== want.kind || rsp_ch.out_port !== want.out_port ||
                rsp_ch.out_seq !== want.out_seq || rsp_ch.last !== want.last) begin
               flag_error($sformatf(
                  "expected kind %0d port %h seq %h last %b, got kind %0d port %h seq %h last %b",
                  want.kind, want.out_port, want.out_seq, want.last,
                  rsp_ch.kind, rsp_ch.out_port, rsp_ch.out_seq, rsp_ch.last));
            end
         end
      end
   end

   // Watchdog: too long with no word moving on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Commands on an empty list: tick gives nothing, cancel misses,
   // unused opcode is dropped.
   task automatic test_empty_list();
      send_word(OP_TICK, '0, '0, '0);
      send_word(OP_CANCEL, '0, '0, 32'h0000_0000);
      send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      wait_drained();
   endtask

   // Placement rules and every cancel position.
   task automatic test_insert_order();
      send_word(OP_ADD, 16'd5, 16'h0101, 32'd1);       // first entry becomes head
      send_word(OP_ADD, 16'd5, 16'h0202, 32'd2);       // equal to head: goes in front
      send_word(OP_ADD, 16'hFFFF, 16'h0303, 32'd3);    // longest delay: tail
      send_word(OP_ADD, 16'd0, 16'h0404, 32'd4);       // zero delay: new head
      send_word(OP_ADD, 16'd5, 16'h0505, 32'd5);       // tie past the head: goes after
      send_word(OP_CANCEL, '0, '0, 32'd1);             // middle
      send_word(OP_CANCEL, '0, '0, 32'd3);             // tail
      send_word(OP_TICK, '0, '0, '0);                  // head at zero: saturate, pop
      send_word(OP_CANCEL, '0, '0, 32'd2);             // head
      send_word(OP_CANCEL, '0, '0, 32'd5);             // only entry left
      wait_drained();
   endtask

   // Fill the table, see an add bounced, then expire all entries in one tick.
   task automatic test_full_table();
      for (int i = 0; i < QDEPTH; i++)
         send_word(OP_ADD, 16'd1, i[0] ? 16'hFFFF : 16'h0000,
                   i[0] ? 32'hFFFF_FFFF - i : i);
      send_word(OP_ADD, 16'd2, 16'hA5A5, 32'h5A5A_5A5A);
      send_word(OP_TICK, '0, '0, '0);
      wait_drained();
   endtask

   // Mostly well-formed traffic: short delays so ticks expire entries,
   // cancels aimed at live entries, some duplicate seqs, plus noise.
   task automatic test_random_traffic(input int n_words, input bit steady);
      int                 pick;
      logic [DELTA_W-1:0] delay;
      logic [SEQ_W-1:0]   seq;
      steady_flow = steady;
      for (int k = 0; k < n_words; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            delay = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
            if (shadow_count > 0 && $urandom_range(0, 7) == 0)
               seq = shadow_seq[$urandom_range(0, shadow_count - 1)];
            else
               seq = $urandom;
            send_word(OP_ADD, delay, 16'($urandom), seq);
         end else if (pick < 65) begin
            if (shadow_count > 0 && $urandom_range(0, 4) != 0)
               seq = shadow_seq[$urandom_range(0, shadow_count - 1)];
            else
               seq = $urandom;
            send_word(OP_CANCEL, 16'($urandom), 16'($urandom), seq);
         end else if (pick < 95) begin
            send_word(OP_TICK, 16'($urandom), 16'($urandom), $urandom);
         end else begin
            send_word(OP_UNUSED, 16'($urandom), 16'($urandom), $urandom);
         end
      end
      wait_drained();
      steady_flow = 1'b0;
   endtask

   initial begin
      steady_flow  = 1'b0;
      shadow_count = 0;
      for (int i = 0; i < QDEPTH; i++) begin
         shadow_delta[i] = '0;
         shadow_port[i]  = '0;
         shadow_seq[i]   = '0;
      end
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.opcode <= OP_ADD;
      req_ch.delay  <= '0;
      req_ch.port   <= '0;
      req_ch.seq    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_insert_order();
      test_full_table();
      test_random_traffic(120, 1'b0);
      test_random_traffic(60, 1'b1);
      test_random_traffic(120, 1'b0);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/dltq_pkg.sv
hdl/dltq_if.sv
hdl/dltq_entry_ram.sv
hdl/dltq_rsp_reg.sv
hdl/dltq_seq.sv
hdl/delta_list_timer_queue_core.sv
tb/delta_list_timer_queue_core_tb.sv
